>>> hw/rtl/ter_pkg.sv
// ter_pkg: shared constants, types and helpers for the triangle edge rasterizer
// no dependencies; used by ter_ctrl, ter_dp and triangle_edge_rasterizer_core
package ter_pkg;

  localparam int unsigned MaxDimDefault = 4096;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned DomW    = 13;
  localparam int unsigned PixW    = 12;
  localparam int unsigned BaryW   = 17;
  // edge values of 12.4 vertices fit in 34 signed bits
  localparam int unsigned EdgeW   = 34;
  localparam int unsigned MagW    = 33;
  // quotient of |w|<<16 by |A|: w <= A when covered, so 17 quotient bits suffice
  localparam int unsigned QuoW    = 17;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  localparam logic [0:0] RegDomainWidth  = 1'b0;
  localparam logic [0:0] RegDomainHeight = 1'b1;

  // controller states, one-hot
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StEdge  = 5'b00010,
    StDiv   = 5'b00100,
    StFinal = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // latch vertices and set up triangle
    logic setup2;     // finish setup: area, box and classes
    logic step_eval;  // evaluate edge functions at walk position
    logic div_start;  // start the three divisions
    logic div_step;   // one restoring step
    logic step_fin;   // form step result and advance walk
    logic idle_res;   // form idle step result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_active;
    logic pix_in;
    logic div_last;
  } dp_sts_t;

endpackage

>>> hw/rtl/ter_ctrl.sv
// ter_ctrl: sequencer for load, pixel evaluation, division and result handoff
// depends on ter_pkg
module ter_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ter_pkg::dp_cmd_t  cmd_o,
  input  ter_pkg::dp_sts_t  sts_i
);

  ter_pkg::state_e state_q, state_d;
  logic            in_acc;

  assign in_stall_o  = (state_q != ter_pkg::StIdle);
  assign in_acc      = in_valid_i && (state_q == ter_pkg::StIdle);
  assign out_valid_o = (state_q == ter_pkg::StOut);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ter_pkg::StIdle: begin
        if (in_acc) begin
          if (func_i == ter_pkg::FuncLoad) begin
            cmd_o.load = 1'b1;
            state_d    = ter_pkg::StFinal;
          end else if (sts_i.walk_active) begin
            cmd_o.step_eval = 1'b1;
            state_d         = ter_pkg::StEdge;
          end else begin
            cmd_o.idle_res = 1'b1;
            state_d        = ter_pkg::StOut;
          end
        end
      end
      ter_pkg::StEdge: begin
        if (sts_i.pix_in) begin
          cmd_o.div_start = 1'b1;
          state_d         = ter_pkg::StDiv;
        end else begin
          cmd_o.step_fin = 1'b1;
          state_d        = ter_pkg::StOut;
        end
      end
      ter_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ter_pkg::StFinal;
        end
      end
      ter_pkg::StFinal: begin
        // after load: second setup step; after divide: result
        cmd_o.setup2   = 1'b1;
        cmd_o.step_fin = 1'b1;
        state_d        = ter_pkg::StOut;
      end
      ter_pkg::StOut: begin
        if (!out_stall_i) begin
          state_d = ter_pkg::StIdle;
        end
      end
      default: state_d = ter_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ter_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ter_pkg::StIdle) |-> in_stall_o)
    else $error("input taken while busy");
  a_div_from_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ter_pkg::StDiv) |-> $past(state_q == ter_pkg::StEdge))
    else $error("divide entered out of order");

endmodule

>>> hw/rtl/ter_dp.sv
// ter_dp: triangle setup, edge evaluation, serial divider and walk counters
// depends on ter_pkg
module ter_dp #(
  parameter int unsigned MaxDim = ter_pkg::MaxDimDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ter_pkg::dp_cmd_t                  cmd_i,
  output ter_pkg::dp_sts_t                  sts_o,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [ter_pkg::DomW-1:0]          cfg_data_i,
  input  logic signed [ter_pkg::CoordW-1:0] v0_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v0_y_i,
  input  logic signed [ter_pkg::CoordW-1:0] v1_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v1_y_i,
  input  logic signed [ter_pkg::CoordW-1:0] v2_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v2_y_i,
  output logic                              covered_o,
  output logic [ter_pkg::PixW-1:0]          pixel_x_o,
  output logic [ter_pkg::PixW-1:0]          pixel_y_o,
  output logic [ter_pkg::BaryW-1:0]         bary_a_o,
  output logic [ter_pkg::BaryW-1:0]         bary_b_o,
  output logic [ter_pkg::BaryW-1:0]         bary_c_o,
  output logic                              done_res_o,
  output logic                              counter_clockwise_o
);

  localparam int unsigned CW = ter_pkg::CoordW;
  localparam int unsigned EW = ter_pkg::EdgeW;
  localparam int unsigned MW = ter_pkg::MagW;
  localparam int unsigned QW = ter_pkg::QuoW;
  localparam int unsigned DW = ter_pkg::DomW;
  // a limit beyond the register range never clamps
  localparam logic [DW-1:0] MaxDimV = (MaxDim >= (1 << DW)) ? {DW{1'b1}} : DW'(MaxDim);

  // configuration
  logic [DW-1:0] dom_w_q, dom_h_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_w_q <= DW'(640);
      dom_h_q <= DW'(480);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ter_pkg::RegDomainWidth) dom_w_q <= cfg_data_i;
      else                                      dom_h_q <= cfg_data_i;
    end
  end

  // vertex store
  logic signed [CW-1:0] vx_q [3];
  logic signed [CW-1:0] vy_q [3];
  logic signed [EW-1:0] area_q;
  logic [1:0]           ecls_q [3];
  logic [DW-1:0]        lo_x_q, lo_y_q, hi_x_q, hi_y_q, wx_q, wy_q;
  logic                 active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      vx_q[0] <= v0_x_i; vy_q[0] <= v0_y_i;
      vx_q[1] <= v1_x_i; vy_q[1] <= v1_y_i;
      vx_q[2] <= v2_x_i; vy_q[2] <= v2_y_i;
    end
  end

  // edge functions at the selected point: one multiplier pair per edge
  logic signed [CW+1:0]  px, py;
  logic signed [EW-1:0]  w [3];

  always_comb begin
    logic signed [CW+1:0] dax, day, dbx, dby;
    if (cmd_i.setup2) begin
      // area: edge 0 evaluated at vertex 0
      px = (CW+2)'(vx_q[0]);
      py = (CW+2)'(vy_q[0]);
    end else begin
      px = $signed({1'b0, wx_q, 4'h8});
      py = $signed({1'b0, wy_q, 4'h8});
    end
    for (int k = 0; k < 3; k++) begin
      dax = (CW+2)'(vx_q[(k+1)%3]) - px;
      day = (CW+2)'(vy_q[(k+1)%3]) - py;
      dbx = (CW+2)'(vx_q[(k+2)%3]) - px;
      dby = (CW+2)'(vy_q[(k+2)%3]) - py;
      w[k] = EW'(dax * dby) - EW'(dbx * day);
    end
  end

  // setup: box and edge classes (cycle after load)
  logic signed [CW-1:0] mnx, mny, mxx, mxy;
  logic [DW-1:0] blx, bly, bhx, bhy, dwc, dhc;
  logic          sgn_pos, sgn_neg;
  always_comb begin
    mnx = vx_q[0]; mxx = vx_q[0]; mny = vy_q[0]; mxy = vy_q[0];
    for (int k = 1; k < 3; k++) begin
      if (vx_q[k] < mnx) mnx = vx_q[k];
      if (vx_q[k] > mxx) mxx = vx_q[k];
      if (vy_q[k] < mny) mny = vy_q[k];
      if (vy_q[k] > mxy) mxy = vy_q[k];
    end
    blx = mnx[CW-1] ? '0 : DW'(mnx[CW-2:4]);
    bly = mny[CW-1] ? '0 : DW'(mny[CW-2:4]);
    bhx = mxx[CW-1] ? '0 : DW'(mxx[CW-2:4]);
    bhy = mxy[CW-1] ? '0 : DW'(mxy[CW-2:4]);
    dwc = (dom_w_q > MaxDimV) ? MaxDimV : dom_w_q;
    dhc = (dom_h_q > MaxDimV) ? MaxDimV : dom_h_q;
    if (bhx > dwc) bhx = dwc;
    if (bhy > dhc) bhy = dhc;
    sgn_pos = (w[0] > 0);
    sgn_neg = (w[0] < 0);
  end

  // pixel test latched from the evaluation cycle
  logic signed [EW-1:0] wl_q [3];
  logic                 inside_q;
  logic                 inside_d;
  always_comb begin
    inside_d = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (!((area_q > 0 && w[k] > 0) || (area_q < 0 && w[k] < 0) ||
            (w[k] == 0 && ecls_q[k] != 2'b00))) inside_d = 1'b0;
    end
  end

  // restoring division, three lanes sharing one step counter
  logic [MW:0]      rem_q [3];
  logic [QW-1:0]    quo_q [3];
  logic [MW+QW-1:0] num_q [3];
  logic [MW-1:0]    den_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_eval) begin
      for (int k = 0; k < 3; k++) wl_q[k] <= w[k];
      inside_q <= inside_d;
    end
    if (cmd_i.div_start) begin
      den_q <= area_q[EW-1] ? MW'(-area_q) : MW'(area_q);
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= {1'b0, (wl_q[k][EW-1] ? MW'(-wl_q[k]) : MW'(wl_q[k])), 16'h0};
        rem_q[k] <= '0;
        quo_q[k] <= '0;
      end
    end else if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        logic [MW:0] t;
        t = {rem_q[k][MW-1:0], num_q[k][MW+QW-1]};
        num_q[k] <= {num_q[k][MW+QW-2:0], 1'b0};
        if (t >= {1'b0, den_q}) begin
          rem_q[k] <= t - {1'b0, den_q};
          quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= t;
          quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  // step count: MW+QW numerator bits
  localparam int unsigned Steps = MW + QW;
  localparam int unsigned SCW = $clog2(Steps + 1);
  logic [SCW-1:0] sc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sc_q <= '0;
    else if (cmd_i.div_start) sc_q <= '0;
    else if (cmd_i.div_step) sc_q <= sc_q + 1'b1;
  end

  // setup state, walk counters
  logic phase_load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q   <= '0;
      active_q <= 1'b0;
      lo_x_q <= '0; lo_y_q <= '0; hi_x_q <= '0; hi_y_q <= '0;
      wx_q <= '0; wy_q <= '0;
      phase_load_q <= 1'b0;
      for (int k = 0; k < 3; k++) ecls_q[k] <= '0;
    end else begin
      if (cmd_i.load) phase_load_q <= 1'b1;
      if (cmd_i.setup2 && phase_load_q) begin
        phase_load_q <= 1'b0;
        area_q <= w[0];
        for (int k = 0; k < 3; k++) begin
          logic signed [CW:0] dy, dx;
          dy = (CW+1)'(vy_q[(k+1)%3]) - (CW+1)'(vy_q[(k+2)%3]);
          dx = (CW+1)'(vx_q[(k+2)%3]) - (CW+1)'(vx_q[(k+1)%3]);
          ecls_q[k][0] <= (sgn_pos && dy > 0) || (sgn_neg && dy < 0);
          ecls_q[k][1] <= (dy == 0) && ((sgn_pos && dx > 0) || (sgn_neg && dx < 0));
        end
        lo_x_q <= blx; lo_y_q <= bly; hi_x_q <= bhx; hi_y_q <= bhy;
        wx_q <= blx; wy_q <= bly;
        active_q <= (sgn_pos || sgn_neg) && (blx < bhx) && (bly < bhy);
      end else if (cmd_i.step_fin && !phase_load_q) begin
        if (wy_q + 1'b1 >= hi_y_q) begin
          wy_q <= lo_y_q;
          wx_q <= wx_q + 1'b1;
          if (wx_q + 1'b1 >= hi_x_q) active_q <= 1'b0;
        end else begin
          wy_q <= wy_q + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      covered_o <= 1'b0; pixel_x_o <= '0; pixel_y_o <= '0;
      bary_a_o <= '0; bary_b_o <= '0; bary_c_o <= '0;
      done_res_o <= 1'b0; counter_clockwise_o <= 1'b0;
    end else if (cmd_i.idle_res) begin
      covered_o <= 1'b0; pixel_x_o <= '0; pixel_y_o <= '0;
      bary_a_o <= '0; bary_b_o <= '0; bary_c_o <= '0;
      done_res_o <= 1'b1; counter_clockwise_o <= (area_q > 0);
    end else if (cmd_i.setup2 && phase_load_q) begin
      covered_o <= 1'b0; pixel_x_o <= '0; pixel_y_o <= '0;
      bary_a_o <= '0; bary_b_o <= '0; bary_c_o <= '0;
      done_res_o <= !((sgn_pos || sgn_neg) && (blx < bhx) && (bly < bhy));
      counter_clockwise_o <= sgn_pos;
    end else if (cmd_i.step_fin) begin
      covered_o <= inside_q;
      pixel_x_o <= wx_q[ter_pkg::PixW-1:0];
      pixel_y_o <= wy_q[ter_pkg::PixW-1:0];
      bary_a_o <= inside_q ? quo_q[0] : '0;
      bary_b_o <= inside_q ? quo_q[1] : '0;
      bary_c_o <= inside_q ? quo_q[2] : '0;
      done_res_o <= (wy_q + 1'b1 >= hi_y_q) && (wx_q + 1'b1 >= hi_x_q);
      counter_clockwise_o <= (area_q > 0);
    end
  end

  assign sts_o.walk_active = active_q;
  assign sts_o.pix_in      = inside_d;
  assign sts_o.div_last    = (sc_q == SCW'(Steps - 1));

  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (wx_q < hi_x_q) && (wy_q < hi_y_q))
    else $error("walk outside box");
  a_area_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (area_q != '0))
    else $error("walk on degenerate triangle");
  a_bary_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !covered_o |-> (bary_a_o == '0) && (bary_b_o == '0) && (bary_c_o == '0))
    else $error("weights on uncovered pixel");

endmodule

>>> hw/rtl/triangle_edge_rasterizer_core.sv
// triangle_edge_rasterizer_core: top level, joins ter_ctrl and ter_dp
// depends on ter_pkg, ter_ctrl, ter_dp
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+-------------------------------------
//  in       | in_valid_i  | in_stall_o   | func_i, v0..v2 x/y
//  out      | out_valid_o | out_stall_i  | covered, pixel x/y, bary a/b/c, flags
//  cfg      | cfg_we_i    | -            | cfg_idx_i, cfg_data_i
//
// load: final, then out state; uncovered step: edge, then out; idle step: out
// covered step: edge, the 50-step restoring divider (3 lanes), final, then out
// one item at a time; next item taken once the result leaves the output register
// reset (rst_ni low, async) restores 640x480 domain and clears the triangle
module triangle_edge_rasterizer_core #(
  parameter int unsigned MaxDim = ter_pkg::MaxDimDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [ter_pkg::DomW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [ter_pkg::CoordW-1:0] v0_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v0_y_i,
  input  logic signed [ter_pkg::CoordW-1:0] v1_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v1_y_i,
  input  logic signed [ter_pkg::CoordW-1:0] v2_x_i,
  input  logic signed [ter_pkg::CoordW-1:0] v2_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              covered_o,
  output logic [ter_pkg::PixW-1:0]          pixel_x_o,
  output logic [ter_pkg::PixW-1:0]          pixel_y_o,
  output logic [ter_pkg::BaryW-1:0]         bary_a_o,
  output logic [ter_pkg::BaryW-1:0]         bary_b_o,
  output logic [ter_pkg::BaryW-1:0]         bary_c_o,
  output logic                              done_res_o,
  output logic                              counter_clockwise_o
);

  ter_pkg::dp_cmd_t cmd;
  ter_pkg::dp_sts_t sts;

  ter_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  ter_dp #(.MaxDim(MaxDim)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .v0_x_i, .v0_y_i, .v1_x_i, .v1_y_i, .v2_x_i, .v2_y_i,
    .covered_o, .pixel_x_o, .pixel_y_o, .bary_a_o, .bary_b_o, .bary_c_o,
    .done_res_o, .counter_clockwise_o
  );

endmodule

>>> test/triangle_edge_rasterizer_core_test.sv
// triangle_edge_rasterizer_core_test: self-checking bench for the triangle edge rasterizer
// depends on ter_pkg and triangle_edge_rasterizer_core; predicts every result in a scoreboard
module triangle_edge_rasterizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected result transaction
  typedef struct {
    logic        covered;
    logic [11:0] px;
    logic [11:0] py;
    logic [16:0] ba;
    logic [16:0] bb;
    logic [16:0] bc;
    logic        done;
    logic        ccw;
  } pixel_res_t;

  // raster predictor and queue of pending pixel results
  class raster_scoreboard;
    longint      vtx[6];
    logic [1:0]  eclass[3];
    longint      area2;
    int unsigned lo_x, lo_y, hi_x, hi_y, cur_x, cur_y;
    bit          walking;
    int unsigned dom_w, dom_h;
    pixel_res_t  pending[$];
    int          mismatches;

    function new();
      foreach (vtx[i]) vtx[i] = 0;
      foreach (eclass[i]) eclass[i] = 0;
      area2 = 0; lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
      cur_x = 0; cur_y = 0; walking = 0;
      dom_w = 640; dom_h = 480; mismatches = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [12:0] val);
      if (idx == ter_pkg::RegDomainWidth) dom_w = val;
      else dom_h = val;
    endfunction

    function longint edge_val(longint ax, longint ay, longint bx, longint by,
                              longint px, longint py);
      return (ax - px) * (by - py) - (bx - px) * (ay - py);
    endfunction

    function int unsigned upper_bound(longint hv, int unsigned dom);
      int unsigned h;
      h = hv < 0 ? 0 : int'(hv >>> 4);
      if (dom > ter_pkg::MaxDimDefault) dom = ter_pkg::MaxDimDefault;
      return h > dom ? dom : h;
    endfunction

    // predict the result of one accepted input transaction
    function void note_input(logic fn, logic signed [15:0] c[6]);
      pixel_res_t r;
      longint sgn, mnx, mny, mxx, mxy, ax, ay, bx, by, px, py, den, num;
      longint w[3];
      int a, b;
      bit ins;
      r = '{default: 0};
      if (fn == ter_pkg::FuncLoad) begin
        foreach (vtx[k]) vtx[k] = c[k];
        area2 = edge_val(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
        sgn = area2 > 0 ? 1 : (area2 < 0 ? -1 : 0);
        for (int k = 0; k < 3; k++) begin
          a = (k + 1) % 3; b = (k + 2) % 3;
          ax = vtx[2*a]; ay = vtx[2*a+1]; bx = vtx[2*b]; by = vtx[2*b+1];
          eclass[k] = 0;
          if (sgn * (ay - by) > 0) eclass[k][0] = 1;
          if (ay == by && sgn * (bx - ax) > 0) eclass[k][1] = 1;
        end
        mnx = vtx[0]; mxx = vtx[0]; mny = vtx[1]; mxy = vtx[1];
        for (int k = 1; k < 3; k++) begin
          if (vtx[2*k] < mnx) mnx = vtx[2*k];
          if (vtx[2*k] > mxx) mxx = vtx[2*k];
          if (vtx[2*k+1] < mny) mny = vtx[2*k+1];
          if (vtx[2*k+1] > mxy) mxy = vtx[2*k+1];
        end
        lo_x = mnx < 0 ? 0 : int'(mnx >>> 4);
        lo_y = mny < 0 ? 0 : int'(mny >>> 4);
        hi_x = upper_bound(mxx, dom_w);
        hi_y = upper_bound(mxy, dom_h);
        cur_x = lo_x; cur_y = lo_y;
        walking = area2 != 0 && lo_x < hi_x && lo_y < hi_y;
        r.done = !walking;
        r.ccw = area2 > 0;
      end else begin
        r.ccw = area2 > 0;
        if (!walking) r.done = 1;
        else begin
          px = longint'(cur_x) * 16 + 8;
          py = longint'(cur_y) * 16 + 8;
          sgn = area2 > 0 ? 1 : -1;
          ins = 1;
          for (int k = 0; k < 3; k++) begin
            a = (k + 1) % 3; b = (k + 2) % 3;
            w[k] = edge_val(vtx[2*a], vtx[2*a+1], vtx[2*b], vtx[2*b+1], px, py);
            if (!(sgn * w[k] > 0 || (w[k] == 0 && eclass[k] != 0))) ins = 0;
          end
          r.px = cur_x[11:0];
          r.py = cur_y[11:0];
          if (ins) begin
            den = area2 < 0 ? -area2 : area2;
            r.covered = 1;
            num = w[0] < 0 ? -w[0] : w[0]; r.ba = 17'((num <<< 16) / den);
            num = w[1] < 0 ? -w[1] : w[1]; r.bb = 17'((num <<< 16) / den);
            num = w[2] < 0 ? -w[2] : w[2]; r.bc = 17'((num <<< 16) / den);
          end
          cur_y++;
          if (cur_y >= hi_y) begin
            cur_y = lo_y;
            cur_x++;
            if (cur_x >= hi_x) begin
              walking = 0;
              r.done = 1;
            end
          end
        end
      end
      pending = {pending, r};
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(pixel_res_t got);
      pixel_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
        return;
      end
      e = pending.pop_front();
      if (got.covered !== e.covered || got.px !== e.px || got.py !== e.py ||
          got.ba !== e.ba || got.bb !== e.bb || got.bc !== e.bc ||
          got.done !== e.done || got.ccw !== e.ccw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp cov %0d x %0d y %0d a %0d b %0d c %0d done %0d ccw %0d",
                   e.covered, e.px, e.py, e.ba, e.bb, e.bc, e.done, e.ccw,
                   " got cov %0d x %0d y %0d a %0d b %0d c %0d done %0d ccw %0d",
                   got.covered, got.px, got.py, got.ba, got.bb, got.bc, got.done,
                   got.ccw);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [ter_pkg::DomW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, func_i;
  logic signed [ter_pkg::CoordW-1:0] v0_x_i, v0_y_i, v1_x_i, v1_y_i, v2_x_i, v2_y_i;
  logic out_valid_o, out_stall_i, covered_o, done_res_o, counter_clockwise_o;
  logic [ter_pkg::PixW-1:0] pixel_x_o, pixel_y_o;
  logic [ter_pkg::BaryW-1:0] bary_a_o, bary_b_o, bary_c_o;

  raster_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  longint cycle_count;
  int steps_left;

  triangle_edge_rasterizer_core u_dut (.*);

  // clock
  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall and checking
  always @(posedge clk_i) begin
    pixel_res_t g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      g.covered = covered_o; g.px = pixel_x_o; g.py = pixel_y_o;
      g.ba = bary_a_o; g.bb = bary_b_o; g.bc = bary_c_o;
      g.done = done_res_o; g.ccw = counter_clockwise_o;
      sb.check_result(g);
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // send one input transaction and predict it; valid stays up until the next gap
  task automatic send_item(logic fn, logic signed [15:0] c[6]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; func_i <= fn;
    v0_x_i <= c[0]; v0_y_i <= c[1]; v1_x_i <= c[2];
    v1_y_i <= c[3]; v2_x_i <= c[4]; v2_y_i <= c[5];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(fn, c);
  endtask

  task automatic send_load(int a, int b, int c, int d, int e, int f);
    logic signed [15:0] v[6];
    v = '{16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f)};
    send_item(ter_pkg::FuncLoad, v);
  endtask

  task automatic send_step();
    logic signed [15:0] v[6];
    foreach (v[i]) v[i] = 16'($urandom);
    send_item(ter_pkg::FuncStep, v);
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [12:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // small random triangle near a random origin, sometimes with shared coords
  task automatic random_triangle(int org_x, int org_y, int span);
    int v[6];
    for (int i = 0; i < 6; i++)
      v[i] = ((i % 2) ? org_y : org_x) + $urandom_range(span);
    if ($urandom_range(3) == 0) v[3] = v[1];
    if ($urandom_range(5) == 0) v[4] = v[2];
    if ($urandom_range(9) == 0) begin v[4] = v[0]; v[5] = v[1]; end
    send_load(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  initial begin
    int items;
    sb = new();
    cycle_count = 0;
    cfg_we_i = 0; cfg_idx_i = ter_pkg::RegDomainWidth; cfg_data_i = 0;
    in_valid_i = 0; func_i = ter_pkg::FuncLoad; out_stall_i = 0;
    v0_x_i = 0; v0_y_i = 0; v1_x_i = 0; v1_y_i = 0; v2_x_i = 0; v2_y_i = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: idle step, ccw and cw, degenerate, off-screen, extreme coords
    send_step();
    send_load(0, 0, 64, 0, 0, 64);
    repeat (18) send_step();
    send_load(0, 0, 0, 64, 64, 0);
    repeat (4) send_step();
    send_load(16, 16, 32, 32, 48, 48);
    send_step();
    send_load(-32768, -32768, -32768, -32768 + 32, -32768 + 32, -32768);
    send_load(32767, 32767, -32768, 32767, 32767, -32768);
    send_step();
    send_load(-1, -1, 32767, -32768, -32768, 32767);
    send_step();
    drain();

    // tiny domain, zero domain, and huge domain clamped to max
    write_reg(ter_pkg::RegDomainWidth, 13'd1);
    write_reg(ter_pkg::RegDomainHeight, 13'd1);
    send_load(0, 0, 40, 0, 0, 40);
    repeat (2) send_step();
    drain();
    write_reg(ter_pkg::RegDomainWidth, 13'd0);
    send_load(0, 0, 40, 0, 0, 40);
    send_step();
    drain();
    write_reg(ter_pkg::RegDomainWidth, 13'h1fff);
    write_reg(ter_pkg::RegDomainHeight, 13'h1fff);
    send_load(32767 - 40, 32767 - 40, 32767, 32767 - 40, 32767 - 40, 32767);
    send_step();
    send_load(65500, 65500, 65530, 65500, 65500, 65530);
    repeat (3) send_step();
    drain();

    // random phases over several domain settings
    items = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 21 : (ph == 1 ? 62 : 0);
      recv_idle_pct = ph == 0 ? 62 : (ph == 1 ? 21 : 0);
      write_reg(ter_pkg::RegDomainWidth,
                ph == 2 ? 13'd4096 : 13'($urandom_range(4096, 1)));
      write_reg(ter_pkg::RegDomainHeight,
                ph == 1 ? 13'd4096 : 13'($urandom_range(4096, 1)));
      while (items < 550 * (ph + 1)) begin
        case ($urandom_range(9))
          0: begin
            logic signed [15:0] v[6];
            foreach (v[i]) v[i] = 16'($urandom);
            send_item(ter_pkg::FuncLoad, v);
          end
          1: random_triangle($urandom_range(65535) - 32768,
                             $urandom_range(65535) - 32768, 200);
          default: random_triangle($urandom_range(600), $urandom_range(400), 90);
        endcase
        items++;
        steps_left = $urandom_range(40, 5);
        repeat (steps_left) begin
          send_step();
          items++;
        end
        if (ph == 1 && items % 200 < 40) drain();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/ter_pkg.sv
hw/rtl/ter_ctrl.sv
hw/rtl/ter_dp.sv
hw/rtl/triangle_edge_rasterizer_core.sv
test/triangle_edge_rasterizer_core_test.sv
